// ===== src/mfw_pkg.sv =====
`default_nettype none

package mfw_pkg;

  // pipeline stage indices, shared by the lanes, the merge stage and the control
  localparam int ST_MAG   = 0;
  localparam int ST_BIGT  = 1;
  localparam int ST_TQ    = 2;
  localparam int ST_P1    = 3;
  localparam int ST_A1    = 4;
  localparam int ST_P2    = 5;
  localparam int ST_A2    = 6;
  localparam int ST_P3    = 7;
  localparam int ST_A3    = 8;
  localparam int ST_SPLIT = 9;
  localparam int ST_Q1    = 10;
  localparam int ST_VAL   = 11;
  localparam int ST_PROD  = 12;
  localparam int ST_OUT   = 13;
  localparam int NS       = 14;

  typedef logic [NS-1:0] stage_en_t;

  // register indexes on the configuration port
  localparam logic [1:0] REG_B     = 2'd0;
  localparam logic [1:0] REG_C     = 2'd1;
  localparam logic [1:0] REG_INV_X = 2'd2;
  localparam logic [1:0] REG_INV_Y = 2'd3;

  localparam logic [15:0] RST_B     = 16'd10923;
  localparam logic [15:0] RST_C     = 16'd10923;
  localparam logic [15:0] RST_INV_X = 16'd16384;
  localparam logic [15:0] RST_INV_Y = 16'd16384;

  // datapath widths
  localparam int TQW = 21;           // t as unsigned Q.16
  localparam int KW  = 24;           // coefficient width, signed
  localparam int P1W = KW + TQW + 1;
  localparam int A1W = 27;
  localparam int P2W = A1W + TQW + 1;
  localparam int A2W = 33;
  localparam int P3W = A2W + TQW + 1;
  localparam int A3W = 39;
  localparam int VW  = 32;           // 1d value, signed Q15
  localparam int PW  = 2 * VW;

  localparam int ROUND_Q16 = 32768;
  localparam int ROUND_Q15 = 16384;

  // clamp on |acc| so that the divide by six tops out at 2^31 - 1
  localparam logic [33:0] ACC_MAX = 34'd12884901882;
  // ceil(2^17 / 3) and ceil(2^19 / 3)
  localparam logic [15:0] RECIP3_17 = 16'd43691;
  localparam logic [17:0] RECIP3_19 = 18'd174763;

  typedef struct packed {
    logic signed [KW-1:0] k3_in;
    logic signed [KW-1:0] k2_in;
    logic signed [KW-1:0] k0_in;
    logic signed [KW-1:0] k3_out;
    logic signed [KW-1:0] k2_out;
    logic signed [KW-1:0] k1_out;
    logic signed [KW-1:0] k0_out;
  } coef_t;

endpackage

`default_nettype wire

// ===== src/mfw_coef.sv =====
`default_nettype none

module mfw_coef import mfw_pkg::*; (
  input  logic [15:0] b_param,
  input  logic [15:0] c_param,
  output coef_t       coef
);

  logic signed [KW-1:0] bs;
  logic signed [KW-1:0] cs;

  assign bs = signed'(KW'(b_param));
  assign cs = signed'(KW'(c_param));

  // six times the cubic coefficients, Q15
  assign coef.k3_in  = KW'(393216) - KW'(9) * bs - KW'(6) * cs;
  assign coef.k2_in  = KW'(-589824) + KW'(12) * bs + KW'(6) * cs;
  assign coef.k0_in  = KW'(196608) - KW'(2) * bs;
  assign coef.k3_out = -bs - KW'(6) * cs;
  assign coef.k2_out = KW'(6) * bs + KW'(30) * cs;
  assign coef.k1_out = -(KW'(12) * bs) - KW'(48) * cs;
  assign coef.k0_out = KW'(8) * bs + KW'(24) * cs;

endmodule

`default_nettype wire

// ===== src/mfw_lane.sv =====
`default_nettype none

module mfw_lane import mfw_pkg::*; (
  input  logic                 clk,
  input  stage_en_t            en,
  input  logic signed [15:0]   offset,
  input  logic [15:0]          inv,
  input  coef_t                coef,
  output logic signed [VW-1:0] value
);

  logic [15:0]           mag;
  logic [30:0]           big_t;
  logic [31:0]           bt_full;
  logic [31:0]           tq_sum;
  logic [TQW-1:0]        tq_s2, tq_s3, tq_s4, tq_s5, tq_s6;
  logic                  inner_s2, inner_s3, inner_s4, inner_s5, inner_s6, inner_s7;
  logic signed [TQW:0]   tqs_s2, tqs_s4, tqs_s6;
  logic signed [KW-1:0]  a0, k2_sel, k1_sel, k0_sel;
  logic signed [P1W-1:0] p1, p1_next, r1;
  logic signed [A1W-1:0] a1;
  logic signed [P2W-1:0] p2, p2_next, r2;
  logic signed [A2W-1:0] a2;
  logic signed [P3W-1:0] p3, p3_next, r3;
  logic signed [A3W-1:0] a3;
  logic [A3W-2:0]        acc_mag;
  logic [33:0]           acc_clamp;
  logic [34:0]           acc_sum;
  logic [16:0]           hi_s9, hi_s10;
  logic [15:0]           lo_s9, lo_s10;
  logic                  neg_s9, neg_s10;
  logic [32:0]           q1_prod;
  logic [15:0]           q1;
  logic [17:0]           tri_q1;
  logic [17:0]           rem_full;
  logic [17:0]           x3;
  logic [35:0]           q2_prod;
  logic [VW-1:0]         vmag;

  assign bt_full = 32'(mag) * 32'(inv);
  assign tq_sum  = 32'(big_t) + 32'd512;

  assign tqs_s2 = signed'({1'b0, tq_s2});
  assign tqs_s4 = signed'({1'b0, tq_s4});
  assign tqs_s6 = signed'({1'b0, tq_s6});

  assign a0     = inner_s2 ? coef.k3_in : coef.k3_out;
  assign k2_sel = inner_s3 ? coef.k2_in : coef.k2_out;
  assign k1_sel = inner_s5 ? '0 : coef.k1_out;
  assign k0_sel = inner_s7 ? coef.k0_in : coef.k0_out;

  // horner steps, each product rounded back to Q15
  assign p1_next = a0 * tqs_s2;
  assign r1      = (p1 + P1W'(ROUND_Q16)) >>> 16;
  assign p2_next = a1 * tqs_s4;
  assign r2      = (p2 + P2W'(ROUND_Q16)) >>> 16;
  assign p3_next = a2 * tqs_s6;
  assign r3      = (p3 + P3W'(ROUND_Q16)) >>> 16;

  // divide by six, rounded away from zero: halve, then divide by three in two digits
  assign acc_mag   = a3[A3W-1] ? (A3W-1)'(-a3) : (A3W-1)'(a3);
  assign acc_clamp = (acc_mag > (A3W-1)'(ACC_MAX)) ? ACC_MAX : acc_mag[33:0];
  assign acc_sum   = 35'(acc_clamp) + 35'd3;

  assign q1_prod  = 33'(hi_s9) * 33'(RECIP3_17);
  assign tri_q1   = 18'(q1) * 18'd3;
  assign rem_full = 18'(hi_s10) - tri_q1;
  assign x3       = {rem_full[1:0], lo_s10};
  assign q2_prod  = 36'(x3) * 36'(RECIP3_19);
  assign vmag     = {q1, q2_prod[34:19]};

  always_ff @(posedge clk) begin
    if (en[ST_MAG]) begin
      mag <= offset[15] ? 16'(-offset) : 16'(offset);
    end
    if (en[ST_BIGT]) begin
      big_t <= bt_full[30:0];
    end
    if (en[ST_TQ]) begin
      tq_s2    <= tq_sum[30:10];
      inner_s2 <= (tq_sum[30:10] <= TQW'(65536));
    end
    if (en[ST_P1]) begin
      p1       <= p1_next;
      tq_s3    <= tq_s2;
      inner_s3 <= inner_s2;
    end
    if (en[ST_A1]) begin
      a1       <= A1W'(r1) + A1W'(k2_sel);
      tq_s4    <= tq_s3;
      inner_s4 <= inner_s3;
    end
    if (en[ST_P2]) begin
      p2       <= p2_next;
      tq_s5    <= tq_s4;
      inner_s5 <= inner_s4;
    end
    if (en[ST_A2]) begin
      a2       <= A2W'(r2) + A2W'(k1_sel);
      tq_s6    <= tq_s5;
      inner_s6 <= inner_s5;
    end
    if (en[ST_P3]) begin
      p3       <= p3_next;
      inner_s7 <= inner_s6;
    end
    if (en[ST_A3]) begin
      a3 <= A3W'(r3) + A3W'(k0_sel);
    end
    if (en[ST_SPLIT]) begin
      hi_s9  <= acc_sum[33:17];
      lo_s9  <= acc_sum[16:1];
      neg_s9 <= a3[A3W-1];
    end
    if (en[ST_Q1]) begin
      q1      <= q1_prod[32:17];
      hi_s10  <= hi_s9;
      lo_s10  <= lo_s9;
      neg_s10 <= neg_s9;
    end
    if (en[ST_VAL]) begin
      value <= neg_s10 ? -signed'(vmag) : signed'(vmag);
    end
  end

endmodule

`default_nettype wire

// ===== src/mfw_merge.sv =====
`default_nettype none

module mfw_merge import mfw_pkg::*; (
  input  logic                 clk,
  input  stage_en_t            en,
  input  logic signed [VW-1:0] value_x,
  input  logic signed [VW-1:0] value_y,
  output logic signed [15:0]   weight
);

  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] prod_next;
  logic signed [PW-1:0] scaled;
  logic signed [15:0]   weight_next;

  assign prod_next = value_x * value_y;
  assign scaled    = (prod + PW'(ROUND_Q15)) >>> 15;

  always_comb begin
    if (scaled > PW'(32767)) begin
      weight_next = 16'sd32767;
    end else if (scaled < PW'(-32768)) begin
      weight_next = -16'sd32768;
    end else begin
      weight_next = 16'(scaled);
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_PROD]) begin
      prod <= prod_next;
    end
    if (en[ST_OUT]) begin
      weight <= weight_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/mitchell_filter_weight_2d.sv =====
// 2d mitchell-netravali filter weight, one x lane and one y lane feeding a product stage
// pipeline: 14 stages, the weight shows on m_tvalid when the item reaches the last stage, ST_OUT
// throughput: one item per cycle; each stage holds only while the stages after it are full
// and the output waits, so bubbles close up under backpressure
// reset (synchronous, active high) empties the pipeline and loads the default b, c and widths

`default_nettype none

module mitchell_filter_weight_2d import mfw_pkg::*; (
  input  logic        clk,
  input  logic        rst,

  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [15:0] offset_x, [31:16] offset_y

  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [15:0] weight

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0]          b_param;
  logic [15:0]          c_param;
  logic [15:0]          inv_x_width;
  logic [15:0]          inv_y_width;
  logic [1:0]           reg_sel;
  logic                 cfg_wr;
  stage_en_t            vld;
  stage_en_t            en;
  coef_t                coef;
  logic signed [VW-1:0] value_x;
  logic signed [VW-1:0] value_y;
  logic signed [15:0]   weight;

  assign pready  = 1'b1;
  assign reg_sel = paddr[3:2];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_param     <= RST_B;
      c_param     <= RST_C;
      inv_x_width <= RST_INV_X;
      inv_y_width <= RST_INV_Y;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_B:     b_param     <= pwdata[15:0];
        REG_C:     c_param     <= pwdata[15:0];
        REG_INV_X: inv_x_width <= pwdata[15:0];
        REG_INV_Y: inv_y_width <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_B:     prdata = 32'(b_param);
      REG_C:     prdata = 32'(c_param);
      REG_INV_X: prdata = 32'(inv_x_width);
      REG_INV_Y: prdata = 32'(inv_y_width);
      default:   prdata = '0;
    endcase
  end

  // a stage may load when the output drains or some stage at or after it is empty
  always_comb begin
    for (int k = 0; k < NS; k++) begin
      en[k] = m_tready || ((vld >> k) != ({NS{1'b1}} >> k));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (en[k]) begin
          vld[k] <= (k == 0) ? s_tvalid : vld[(k == 0) ? 0 : k - 1];
        end
      end
    end
  end

  assign s_tready = en[ST_MAG];
  assign m_tvalid = vld[ST_OUT];
  assign m_tdata  = weight;

  mfw_coef u_coef (
    .b_param (b_param),
    .c_param (c_param),
    .coef    (coef)
  );

  mfw_lane u_lane_x (
    .clk    (clk),
    .en     (en),
    .offset (signed'(s_tdata[15:0])),
    .inv    (inv_x_width),
    .coef   (coef),
    .value  (value_x)
  );

  mfw_lane u_lane_y (
    .clk    (clk),
    .en     (en),
    .offset (signed'(s_tdata[31:16])),
    .inv    (inv_y_width),
    .coef   (coef),
    .value  (value_y)
  );

  mfw_merge u_merge (
    .clk     (clk),
    .en      (en),
    .value_x (value_x),
    .value_y (value_y),
    .weight  (weight)
  );

endmodule

`default_nettype wire
